/* src/fqr_pkg.sv */
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and constants for the queue with in-place reverse.
// ----------------------------------------------------------------------------
package fqr_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int DATA_W        = 32;
  localparam int OCC_W         = 8;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  localparam int OUT_TDATA_W   = DATA_W + OCC_W;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REVERSE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

/* src/fqr_ram.sv */
// ----------------------------------------------------------------------------
// fqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqr_ram #(
  parameter int WIDTH = fqr_pkg::DATA_W,
  parameter int DEPTH = fqr_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fifo_queue_with_reverse.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_reverse
// Bounded queue of 32-bit words with enqueue, dequeue and in-place reverse.
// ----------------------------------------------------------------------------
// One operation is taken at a time; s_tready is high only while the block is
// idle. An enqueue, an empty dequeue or a short reverse goes from S_EXEC
// to S_RESP, a dequeue adds a RAM read in S_RD_WAIT, and a reverse of n
// words makes floor(n/2) swaps, each two reads and two writes through the
// store plus one compare. Slot addresses, but the dequeue read at head, come
// from one shared add-and-wrap unit. A result waiting on m_tready holds the
// block in its response state. Words live in a circular RAM of DEPTH
// entries; occupancy reports the count masked to 8 bits.
module fifo_queue_with_reverse #(
  parameter int DEPTH = fqr_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fqr_pkg::DATA_W-1:0]       s_tdata,  // value
  input  logic [fqr_pkg::OP_W-1:0]         s_tuser,  // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fqr_pkg::OUT_TDATA_W-1:0]  m_tdata,  // data_out, occupancy
  output logic [fqr_pkg::ST_W-1:0]         m_tuser   // status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_CHECK,
    S_RD_A,
    S_RD_B,
    S_WR_A,
    S_WR_B,
    S_RESP
  } state_t;

  state_t                        state;
  fqr_pkg::op_t                  op;
  logic [fqr_pkg::DATA_W-1:0]    value;
  logic [IW-1:0]                 head;
  logic [CW-1:0]                 count;
  logic [IW-1:0]                 lo;
  logic [IW-1:0]                 hi;
  logic [fqr_pkg::DATA_W-1:0]    tmp;
  fqr_pkg::status_t              res_status;
  logic [fqr_pkg::DATA_W-1:0]    res_data;

  logic [CW-1:0]                 off;
  logic [CW:0]                   sum;
  logic [IW-1:0]                 slot;
  logic                          full;
  logic                          empty;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [fqr_pkg::DATA_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [IW-1:0]                 ram_raddr;
  logic [fqr_pkg::DATA_W-1:0]    ram_rdata;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == CW'(0));
  assign s_tready = (state == S_IDLE);

  // shared slot unit: (head + offset) wrapped into the store
  always_comb begin
    case (state)
      S_EXEC: begin
        off = (op == fqr_pkg::OP_ENQUEUE) ? count : CW'(1);
      end
      S_RD_A, S_WR_A: off = CW'(lo);
      S_RD_B, S_WR_B: off = CW'(hi);
      default:        off = CW'(0);
    endcase
    sum  = (CW+1)'(head) + (CW+1)'(off);
    slot = (sum >= (CW+1)'(DEPTH)) ? IW'(sum - (CW+1)'(DEPTH)) : IW'(sum);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = value;
    ram_re    = 1'b0;
    ram_raddr = slot;
    case (state)
      S_EXEC: begin
        ram_we    = (op == fqr_pkg::OP_ENQUEUE) && !full;
        ram_re    = (op == fqr_pkg::OP_DEQUEUE) && !empty;
        ram_raddr = head;
      end
      S_RD_A, S_RD_B: ram_re = 1'b1;
      S_WR_A: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_WR_B: begin
        ram_we    = 1'b1;
        ram_wdata = tmp;
      end
      default: ;
    endcase
  end

  fqr_ram #(
    .WIDTH (fqr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= fqr_pkg::op_t'(s_tuser);
            value <= s_tdata;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= fqr_pkg::ST_DONE;
          res_data   <= '0;
          state      <= S_RESP;
          case (op)
            fqr_pkg::OP_ENQUEUE: begin
              if (full) begin
                res_status <= fqr_pkg::ST_FULL;
              end else begin
                count <= CW'(count + CW'(1));
              end
            end
            fqr_pkg::OP_DEQUEUE: begin
              if (empty) begin
                res_status <= fqr_pkg::ST_EMPTY;
                res_data   <= '1;
              end else begin
                head  <= slot;
                count <= CW'(count - CW'(1));
                state <= S_RD_WAIT;
              end
            end
            fqr_pkg::OP_REVERSE: begin
              if (count >= CW'(2)) begin
                lo    <= '0;
                hi    <= IW'(count - CW'(1));
                state <= S_CHECK;
              end
            end
            default: ;
          endcase
        end
        S_RD_WAIT: begin
          res_data <= ram_rdata;
          state    <= S_RESP;
        end
        S_CHECK: begin
          state <= (lo < hi) ? S_RD_A : S_RESP;
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          tmp   <= ram_rdata;
          state <= S_WR_A;
        end
        S_WR_A: state <= S_WR_B;
        S_WR_B: begin
          lo    <= IW'(lo + IW'(1));
          hi    <= IW'(hi - IW'(1));
          state <= S_CHECK;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {fqr_pkg::OCC_W'(count), res_data};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/fqr_checker.sv */
// ----------------------------------------------------------------------------
// fqr_checker
// Port-level checks for the queue with reverse, bound to the top level.
// ----------------------------------------------------------------------------
module fqr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fqr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [fqr_pkg::ST_W-1:0]        m_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // one operation at a time
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while operation in progress");

  // empty dequeue returns all ones and zero occupancy
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fqr_pkg::ST_EMPTY |->
      m_tdata[fqr_pkg::DATA_W-1:0] == '1 &&
      m_tdata[fqr_pkg::OUT_TDATA_W-1:fqr_pkg::DATA_W] == '0)
    else $error("empty dequeue result malformed");

  // dropped enqueue returns zero data
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fqr_pkg::ST_FULL |-> m_tdata[fqr_pkg::DATA_W-1:0] == '0)
    else $error("full enqueue result carries data");

endmodule

bind fifo_queue_with_reverse fqr_checker u_fqr_checker (.*);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the bounded word queue with in-place reverse. Beats
// of enqueue, dequeue, reverse and the unused operation code are sent with
// random gaps while the result side stalls at random. A circular-store
// predictor inside the bench works out each result, and a checker compares
// every result beat field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fqr_pkg::*;

  localparam int QDEPTH = DEPTH_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1150;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    status_t              st;
    logic [DATA_W-1:0]    word;
    logic [OCC_W-1:0]     occ;
  } queue_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata;       // value
  logic [OP_W-1:0] s_tuser;         // operation
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;  // data_out, occupancy
  logic [ST_W-1:0] m_tuser;         // status

  // predictor state: circular store, front position, fill level
  logic [DATA_W-1:0] word_store [QDEPTH];
  int front_pos;
  int held;

  queue_result_t expected_results[$];
  queue_result_t oldest_result;

  int fail_count;
  int checked_count;
  int op_counts [4];
  int full_drops;
  int empty_reads;
  int max_held;
  int rx_stall_left;
  bit no_idle;

  fifo_queue_with_reverse dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic queue_result_t apply_queue_op(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] word);
    queue_result_t r;
    int lo;
    int hi;
    logic [DATA_W-1:0] t;
    r.st = ST_DONE;
    r.word = '0;
    case (op)
      OP_ENQUEUE: begin
        if (held >= QDEPTH) begin
          r.st = ST_FULL;
          full_drops++;
        end else begin
          word_store[(front_pos + held) % QDEPTH] = word;
          held++;
        end
      end
      OP_DEQUEUE: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
          r.word = '1;
          empty_reads++;
        end else begin
          r.word = word_store[front_pos];
          front_pos = (front_pos + 1) % QDEPTH;
          held--;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = held - 1;
        while (lo < hi) begin
          t = word_store[(front_pos + lo) % QDEPTH];
          word_store[(front_pos + lo) % QDEPTH] = word_store[(front_pos + hi) % QDEPTH];
          word_store[(front_pos + hi) % QDEPTH] = t;
          lo++;
          hi--;
        end
      end
      default: begin
      end
    endcase
    r.occ = held[OCC_W-1:0];
    if (held > max_held) begin
      max_held = held;
    end
    return r;
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    op_counts[op]++;
    expected_results.push_back(apply_queue_op(op, word));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_cases();
    send_beat(OP_DEQUEUE, 32'h1234_5678);
    send_beat(OP_REVERSE, 32'hffff_ffff);
    send_beat(OP_UNUSED, 32'hffff_ffff);
    send_beat(OP_ENQUEUE, 32'h1234_5678);
    send_beat(OP_REVERSE, 32'h0);
    send_beat(OP_DEQUEUE, 32'h0);
    send_beat(OP_DEQUEUE, 32'hdead_beef);
  endtask

  task automatic test_edge_values();
    send_beat(OP_ENQUEUE, 32'h8000_0000);
    send_beat(OP_ENQUEUE, 32'h7fff_ffff);
    send_beat(OP_ENQUEUE, 32'h0000_0000);
    send_beat(OP_ENQUEUE, 32'hffff_ffff);
    send_beat(OP_ENQUEUE, 32'haaaa_aaaa);
    send_beat(OP_ENQUEUE, 32'h5555_5555);
    send_beat(OP_UNUSED, 32'h5555_5555);
    send_beat(OP_REVERSE, 32'haaaa_aaaa);
    repeat (7) send_beat(OP_DEQUEUE, $urandom);
  endtask

  task automatic test_fill_overflow_reverse();
    repeat (QDEPTH) send_beat(OP_ENQUEUE, pick_word());
    send_beat(OP_ENQUEUE, 32'h7fff_ffff);
    send_beat(OP_ENQUEUE, 32'h8000_0000);
    send_beat(OP_ENQUEUE, $urandom);
    send_beat(OP_REVERSE, $urandom);
    send_beat(OP_UNUSED, $urandom);
    repeat (QDEPTH) send_beat(OP_DEQUEUE, $urandom);
    send_beat(OP_DEQUEUE, $urandom);
  endtask

  task automatic test_drain_pause();
    repeat (5) send_beat(OP_ENQUEUE, pick_word());
    wait_drained();
    send_beat(OP_REVERSE, $urandom);
    send_beat(OP_DEQUEUE, $urandom);
    send_beat(OP_DEQUEUE, $urandom);
  endtask

  task automatic test_random_mix();
    int phase;
    int phase_left;
    int r;
    logic [OP_W-1:0] op;
    phase = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(40, 250);
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
        end
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (phase)
        0: op = (r < 78) ? OP_ENQUEUE : (r < 92) ? OP_DEQUEUE :
                (r < 98) ? OP_REVERSE : OP_UNUSED;
        1: op = (r < 15) ? OP_ENQUEUE : (r < 91) ? OP_DEQUEUE :
                (r < 98) ? OP_REVERSE : OP_UNUSED;
        default: op = (r < 45) ? OP_ENQUEUE : (r < 90) ? OP_DEQUEUE :
                      (r < 97) ? OP_REVERSE : OP_UNUSED;
      endcase
      send_beat(op, pick_word());
    end
    no_idle = 1'b0;
  endtask

  // result side stalls
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      m_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        rx_stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with none expected, got status %0d data %h occ %0d",
                 $time, m_tuser, m_tdata[DATA_W-1:0], m_tdata[OUT_TDATA_W-1:DATA_W]);
      end else begin
        oldest_result = expected_results.pop_front();
        checked_count++;
        if (m_tuser !== oldest_result.st) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, oldest_result.st, m_tuser);
        end
        if (m_tdata[DATA_W-1:0] !== oldest_result.word) begin
          fail_count++;
          $display("%0t: data_out mismatch, expected %h, got %h",
                   $time, oldest_result.word, m_tdata[DATA_W-1:0]);
        end
        if (m_tdata[OUT_TDATA_W-1:DATA_W] !== oldest_result.occ) begin
          fail_count++;
          $display("%0t: occupancy mismatch, expected %0d, got %0d",
                   $time, oldest_result.occ, m_tdata[OUT_TDATA_W-1:DATA_W]);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_ENQUEUE;
    m_tready = 1'b0;
    rx_stall_left = 0;
    no_idle = 1'b0;
    front_pos = 0;
    held = 0;
    fail_count = 0;
    checked_count = 0;
    full_drops = 0;
    empty_reads = 0;
    max_held = 0;
    op_counts = '{default: 0};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_cases();
    test_edge_values();
    test_fill_overflow_reverse();
    test_drain_pause();
    test_random_mix();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results still expected", $time, expected_results.size());
    end

    $display("beats: %0d enqueue (%0d dropped when full), %0d dequeue (%0d on empty),",
             op_counts[OP_ENQUEUE], full_drops, op_counts[OP_DEQUEUE], empty_reads);
    $display("%0d reverse, %0d unused code; peak fill %0d; %0d results checked",
             op_counts[OP_REVERSE], op_counts[OP_UNUSED], max_held, checked_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
